@@ hdl/pls_pkg.sv @@
// Shared types and constants for the Pareto label set core.
`default_nettype none
package pls_pkg;

  // Field widths of the request and result items
  localparam int unsigned LABEL_W    = 32;
  localparam int unsigned CMD_W      = 2;
  localparam int unsigned INDEX_W    = 4;
  localparam int unsigned STATUS_W   = 2;
  localparam int unsigned COUNT_W    = 5;
  localparam int unsigned IN_DATA_W  = 72;
  localparam int unsigned OUT_DATA_W = 72;

  // Default store depth
  localparam int unsigned MAX_LABELS_DEFAULT = 16;

  typedef enum logic [CMD_W-1:0] {
    CMD_INSERT = 2'd0,
    CMD_APPEND = 2'd1,
    CMD_CLEAR  = 2'd2,
    CMD_READ   = 2'd3
  } cmd_t;

  typedef enum logic [STATUS_W-1:0] {
    STAT_OK        = 2'd0,
    STAT_DOMINATED = 2'd1,
    STAT_FULL      = 2'd2,
    STAT_EMPTY     = 2'd3
  } status_t;

  typedef enum logic {
    ST_IDLE,
    ST_COMPACT
  } state_t;

  // Per-cell control from the sequencer
  typedef struct packed {
    logic occupied;  // cell lies below the label count
    logic compare;   // latch the drop flag against the broadcast label
    logic compact;   // shift one step toward the head where a hole lies at or below
    logic write;     // store the broadcast label here
  } cell_ctrl_t;

endpackage
`default_nettype wire

@@ hdl/pls_cell.sv @@
// One storage cell of the label row: holds a label, its drop flag, and shifts from its neighbor.
`default_nettype none
module pls_cell (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire pls_pkg::cell_ctrl_t           ctrl,
  input  wire logic [pls_pkg::LABEL_W-1:0]   lbl_cost,
  input  wire logic [pls_pkg::LABEL_W-1:0]   lbl_res,
  input  wire logic [pls_pkg::LABEL_W-1:0]   nbr_cost,
  input  wire logic [pls_pkg::LABEL_W-1:0]   nbr_res,
  input  wire logic                          nbr_drop,
  input  wire logic                          hole_in,
  output logic      [pls_pkg::LABEL_W-1:0]   cost,
  output logic      [pls_pkg::LABEL_W-1:0]   res,
  output logic                               drop,
  output logic                               hole_out,
  output logic                               dominates
);
  import pls_pkg::*;

  logic shift;

  // A hole at or below this cell pulls the neighbor's label down
  assign hole_out = hole_in | drop;
  assign shift    = ctrl.compact & hole_out;

  // Stored label dominates the broadcast one
  assign dominates = ctrl.occupied & (cost <= lbl_cost) & (res < lbl_res);

  // Drop flag: set on compare, advance with the shift
  always_ff @(posedge clk) begin
    if (rst) begin
      drop <= 1'b0;
    end else if (ctrl.compare) begin
      drop <= ctrl.occupied & (cost >= lbl_cost) & (res > lbl_res);
    end else if (shift) begin
      drop <= nbr_drop;
    end
  end

  // Label payload: write or shift
  always_ff @(posedge clk) begin
    if (ctrl.write) begin
      cost <= lbl_cost;
      res  <= lbl_res;
    end else if (shift) begin
      cost <= nbr_cost;
      res  <= nbr_res;
    end
  end

endmodule
`default_nettype wire

@@ hdl/pareto_label_set_core.sv @@
// Top level of the Pareto label set: sequencer, cell row and result register.
// Keeps an ordered set of up to MAX_LABELS (cost, resource) labels in a row of cells.
// Append, clear and read requests load their result as they are taken. A Pareto
// insert first compares the new label against every cell at once, then each
// label it removes is squeezed out by one shift of the cell row toward its
// head, and a last step appends or rejects the label. That last step waits
// while the result register still holds an unread result. A request is taken
// only while the result register is empty or being read in the same cycle, so
// a waiting result stalls the input. No clearing pass follows reset.
`default_nettype none
module pareto_label_set_core #(
  parameter int unsigned MAX_LABELS = pls_pkg::MAX_LABELS_DEFAULT
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            s_tvalid,
  output logic                                 s_tready,
  // command[1:0], new_cost[33:2], new_resource[65:34], read_index[69:66], zero pad
  input  wire logic [pls_pkg::IN_DATA_W-1:0]   s_tdata,
  output logic                                 m_tvalid,
  input  wire logic                            m_tready,
  // status[1:0], label_count[6:2], read_cost[38:7], read_resource[70:39], zero pad
  output logic      [pls_pkg::OUT_DATA_W-1:0]  m_tdata
);
  import pls_pkg::*;

  localparam int unsigned CW   = $clog2(MAX_LABELS + 1);
  localparam int unsigned CMPW = (CW > INDEX_W) ? CW : INDEX_W;

  // Request fields
  cmd_t                in_cmd;
  logic [LABEL_W-1:0]  in_cost;
  logic [LABEL_W-1:0]  in_res;
  logic [INDEX_W-1:0]  in_index;

  assign in_cmd   = cmd_t'(s_tdata[1:0]);
  assign in_cost  = s_tdata[33:2];
  assign in_res   = s_tdata[65:34];
  assign in_index = s_tdata[69:66];

  // Sequencer state
  state_t              state;
  state_t              state_next;
  logic [CW-1:0]       count;
  logic [CW-1:0]       count_next;
  logic                dominated;
  logic [LABEL_W-1:0]  held_cost;
  logic [LABEL_W-1:0]  held_res;

  // Handshake strobes, sequencer strobes and result fields
  logic                accept;
  logic                out_free;
  logic                do_compare;
  logic                do_compact;
  logic                do_write;
  logic                out_load;
  status_t             out_status;
  logic [LABEL_W-1:0]  out_cost;
  logic [LABEL_W-1:0]  out_res;

  // Cell row wiring
  logic [LABEL_W-1:0]  lbl_cost;
  logic [LABEL_W-1:0]  lbl_res;
  logic [LABEL_W-1:0]  cell_cost [MAX_LABELS+1];
  logic [LABEL_W-1:0]  cell_res  [MAX_LABELS+1];
  logic [MAX_LABELS:0] cell_drop;
  logic [MAX_LABELS:0] hole;
  logic [MAX_LABELS-1:0] cell_dom;
  logic                any_drop;
  logic                full;
  logic                read_hit;
  logic [LABEL_W-1:0]  read_cost_sel;
  logic [LABEL_W-1:0]  read_res_sel;

  assign out_free = ~m_tvalid | m_tready;
  assign accept   = s_tvalid & s_tready;
  assign any_drop = hole[MAX_LABELS];
  assign full     = (count == CW'(MAX_LABELS));
  assign read_hit = CMPW'(in_index) < CMPW'(count);

  // Broadcast the live request while idle, the held label afterwards
  assign lbl_cost = (state == ST_IDLE) ? in_cost : held_cost;
  assign lbl_res  = (state == ST_IDLE) ? in_res  : held_res;

  // Cell row: each cell takes its upper neighbor's label on a shift
  assign cell_cost[MAX_LABELS] = '0;
  assign cell_res[MAX_LABELS]  = '0;
  assign cell_drop[MAX_LABELS] = 1'b0;
  assign hole[0]               = 1'b0;

  for (genvar i = 0; i < MAX_LABELS; i++) begin : g_cell
    cell_ctrl_t ctrl;
    assign ctrl.occupied = (CW'(i) < count);
    assign ctrl.compare  = do_compare;
    assign ctrl.compact  = do_compact;
    assign ctrl.write    = do_write & (count == CW'(i));

    pls_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .ctrl      (ctrl),
      .lbl_cost  (lbl_cost),
      .lbl_res   (lbl_res),
      .nbr_cost  (cell_cost[i+1]),
      .nbr_res   (cell_res[i+1]),
      .nbr_drop  (cell_drop[i+1]),
      .hole_in   (hole[i]),
      .cost      (cell_cost[i]),
      .res       (cell_res[i]),
      .drop      (cell_drop[i]),
      .hole_out  (hole[i+1]),
      .dominates (cell_dom[i])
    );
  end

  // Select the addressed cell for a read
  always_comb begin
    read_cost_sel = '0;
    read_res_sel  = '0;
    for (int i = 0; i < MAX_LABELS; i++) begin
      if (CMPW'(i) == CMPW'(in_index)) begin
        read_cost_sel = cell_cost[i];
        read_res_sel  = cell_res[i];
      end
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept && in_cmd == CMD_INSERT) begin
          state_next = ST_COMPACT;
        end
      end
      ST_COMPACT: begin
        if (!any_drop && out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Outputs of the sequencer
  always_comb begin
    s_tready   = 1'b0;
    do_compare = 1'b0;
    do_compact = 1'b0;
    do_write   = 1'b0;
    out_load   = 1'b0;
    out_status = STAT_OK;
    out_cost   = '0;
    out_res    = '0;
    count_next = count;
    case (state)
      ST_IDLE: begin
        s_tready = out_free;
        if (accept) begin
          case (in_cmd)
            CMD_INSERT: begin
              do_compare = 1'b1;
            end
            CMD_APPEND: begin
              out_load = 1'b1;
              if (full) begin
                out_status = STAT_FULL;
              end else begin
                do_write   = 1'b1;
                count_next = count + CW'(1);
              end
            end
            CMD_CLEAR: begin
              out_load   = 1'b1;
              count_next = '0;
            end
            default: begin
              out_load = 1'b1;
              if (read_hit) begin
                out_cost = read_cost_sel;
                out_res  = read_res_sel;
              end else begin
                out_status = STAT_EMPTY;
              end
            end
          endcase
        end
      end
      ST_COMPACT: begin
        if (any_drop) begin
          do_compact = 1'b1;
          count_next = count - CW'(1);
        end else if (out_free) begin
          out_load = 1'b1;
          if (dominated) begin
            out_status = STAT_DOMINATED;
          end else if (full) begin
            out_status = STAT_FULL;
          end else begin
            do_write   = 1'b1;
            count_next = count + CW'(1);
          end
        end
      end
      default: begin
        s_tready = 1'b0;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      count     <= '0;
      dominated <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      if (do_compare) begin
        dominated <= |cell_dom;
      end
    end
  end

  // Hold the offered label through compaction
  always_ff @(posedge clk) begin
    if (do_compare) begin
      held_cost <= in_cost;
      held_res  <= in_res;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      m_tdata <= {1'b0, out_res, out_cost, COUNT_W'(count_next), out_status};
    end
  end

endmodule
`default_nettype wire

@@ bench/tb_top.sv @@
// Testbench for the Pareto label set core: directed and random stream traffic checked against a label-set predictor.
`default_nettype none
module tb_top;
  import pls_pkg::*;

  localparam int unsigned STORE_DEPTH = MAX_LABELS_DEFAULT;
  localparam int unsigned RANDOM_REQUESTS = 600;
  localparam int unsigned LONG_HOLD = 300;
  localparam int unsigned IDLE_LIMIT = 2000;
  localparam int unsigned TAIL_CYCLES = 40;

  typedef struct {
    cmd_t        cmd;
    logic [31:0] cost;
    logic [31:0] res;
    logic [3:0]  idx;
  } label_req_t;

  typedef struct {
    status_t     status;
    logic [4:0]  count;
    logic [31:0] read_cost;
    logic [31:0] read_res;
  } label_res_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [71:0] s_tdata = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [71:0] m_tdata;

  label_req_t pending_requests[$];
  label_res_t expected_results[$];

  // Predictor copy of the label store
  logic [31:0] front_cost [STORE_DEPTH];
  logic [31:0] front_res  [STORE_DEPTH];
  int unsigned front_count = 0;

  int unsigned burst_left = 0;
  int unsigned gap_left = 0;
  int unsigned hold_cycles = 0;
  logic        hold_start = 1'b0;
  logic        hold_taken = 1'b0;
  int unsigned stall_mode = 0;
  int unsigned stall_phase = 0;
  int unsigned idle_cycles = 0;
  int unsigned mismatches = 0;
  int unsigned results_checked = 0;
  int unsigned status_seen [4] = '{0, 0, 0, 0};
  int unsigned cmd_seen [4] = '{0, 0, 0, 0};

  pareto_label_set_core #(.MAX_LABELS(STORE_DEPTH)) dut (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Append a label at the tail of the predicted store unless it is full
  function automatic status_t push_front_label(logic [31:0] cost, logic [31:0] res);
    if (front_count >= STORE_DEPTH) return STAT_FULL;
    front_cost[front_count] = cost;
    front_res[front_count] = res;
    front_count++;
    return STAT_OK;
  endfunction

  // Apply one request to the predicted store and return the result it yields
  function automatic label_res_t apply_label_request(label_req_t req);
    label_res_t  r;
    int unsigned kept;
    bit          dominated;
    r.status = STAT_OK;
    r.read_cost = '0;
    r.read_res = '0;
    case (req.cmd)
      CMD_INSERT: begin
        kept = 0;
        dominated = 1'b0;
        // Squeeze out labels the new one beats, note any label that beats it
        for (int unsigned i = 0; i < front_count; i++) begin
          if (front_cost[i] <= req.cost && front_res[i] < req.res) dominated = 1'b1;
          if (!(front_cost[i] >= req.cost && front_res[i] > req.res)) begin
            front_cost[kept] = front_cost[i];
            front_res[kept] = front_res[i];
            kept++;
          end
        end
        front_count = kept;
        r.status = dominated ? STAT_DOMINATED : push_front_label(req.cost, req.res);
      end
      CMD_APPEND: r.status = push_front_label(req.cost, req.res);
      CMD_CLEAR: front_count = 0;
      default: begin
        if (req.idx < front_count) begin
          r.read_cost = front_cost[req.idx];
          r.read_res = front_res[req.idx];
        end else begin
          r.status = STAT_EMPTY;
        end
      end
    endcase
    r.count = front_count[4:0];
    cmd_seen[req.cmd]++;
    status_seen[r.status]++;
    return r;
  endfunction

  // Drive requests in bursts separated by random gaps
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
      burst_left <= 0;
      gap_left <= 0;
    end else begin
      if (s_tvalid && s_tready) begin
        expected_results.insert(expected_results.size(),
                                apply_label_request(pending_requests.pop_front()));
      end
      if (s_tvalid && !s_tready) begin
        // hold the request until it is taken
      end else if (gap_left != 0) begin
        s_tvalid <= 1'b0;
        gap_left <= gap_left - 1;
      end else if (pending_requests.size() != 0) begin
        s_tvalid <= 1'b1;
        s_tdata <= {2'b00, pending_requests[0].idx, pending_requests[0].res,
                    pending_requests[0].cost, pending_requests[0].cmd};
        if (burst_left > 1) begin
          burst_left <= burst_left - 1;
        end else begin
          burst_left <= $urandom_range(1, 16);
          gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
        end
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // Stall the result side on a changing pattern, with one long hold-off
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else if (hold_cycles != 0) begin
      m_tready <= 1'b0;
      hold_cycles <= hold_cycles - 1;
    end else if (hold_start && !hold_taken) begin
      m_tready <= 1'b0;
      hold_cycles <= LONG_HOLD;
      hold_taken <= 1'b1;
    end else begin
      if (stall_phase == 0) begin
        stall_mode <= $urandom_range(0, 2);
        stall_phase <= 63;
      end else begin
        stall_phase <= stall_phase - 1;
      end
      case (stall_mode)
        0: m_tready <= 1'b1;
        1: m_tready <= 1'($urandom_range(0, 1));
        default: m_tready <= ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  // Compare each accepted result with the oldest prediction
  always @(posedge clk) begin : check_results
    label_res_t want;
    if (!rst && m_tvalid && m_tready) begin
      results_checked++;
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual %h", $time, m_tdata);
        mismatches++;
      end else begin
        want = expected_results.pop_front();
        if (m_tdata[1:0] !== want.status) begin
          $display("%0t: status expected %0d actual %0d", $time, want.status, m_tdata[1:0]);
          mismatches++;
        end
        if (m_tdata[6:2] !== want.count) begin
          $display("%0t: label_count expected %0d actual %0d", $time, want.count,
                   m_tdata[6:2]);
          mismatches++;
        end
        if (m_tdata[38:7] !== want.read_cost) begin
          $display("%0t: read_cost expected %h actual %h", $time, want.read_cost,
                   m_tdata[38:7]);
          mismatches++;
        end
        if (m_tdata[70:39] !== want.read_res) begin
          $display("%0t: read_resource expected %h actual %h", $time, want.read_res,
                   m_tdata[70:39]);
          mismatches++;
        end
      end
    end
  end

  // End the run when nothing moves for too long
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("%0t: no request or result moved for %0d cycles", $time, IDLE_LIMIT);
      $display("FAILED: results differ");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic queue_request(cmd_t cmd, logic [31:0] cost, logic [31:0] res,
                               logic [3:0] idx);
    label_req_t req;
    req.cmd = cmd;
    req.cost = cost;
    req.res = res;
    req.idx = idx;
    pending_requests.insert(pending_requests.size(), req);
  endtask

  task automatic wait_drained();
    while (pending_requests.size() != 0 || expected_results.size() != 0) @(posedge clk);
  endtask

  initial begin : stimulus
    int unsigned sent;
    int unsigned kind;
    int unsigned len;
    int unsigned step;
    int unsigned pick;
    cmd_t        cmd;
    logic [31:0] cost;
    logic [31:0] res;

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // Directed: empty set, equal label, removal on a rejected insert, extremes
    queue_request(CMD_READ, 32'd0, 32'd0, 4'd0);
    queue_request(CMD_INSERT, 32'd100, 32'd100, 4'd0);
    queue_request(CMD_INSERT, 32'd100, 32'd100, 4'd0);
    queue_request(CMD_CLEAR, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 4'hF);
    queue_request(CMD_APPEND, 32'd1, 32'd1, 4'd0);
    queue_request(CMD_APPEND, 32'd10, 32'd10, 4'd0);
    queue_request(CMD_INSERT, 32'd5, 32'd5, 4'd0);
    queue_request(CMD_INSERT, 32'd0, 32'd0, 4'd0);
    queue_request(CMD_INSERT, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 4'd0);
    queue_request(CMD_READ, 32'd0, 32'd0, 4'd0);
    queue_request(CMD_READ, 32'd0, 32'd0, 4'hF);
    // Fill the store, then hit it with an insert and an append
    for (int i = 1; i < STORE_DEPTH; i++) queue_request(CMD_APPEND, 32'd0, 32'd0, 4'd0);
    queue_request(CMD_INSERT, 32'd0, 32'd0, 4'd0);
    queue_request(CMD_APPEND, 32'd7, 32'd7, 4'd0);
    queue_request(CMD_READ, 32'd0, 32'd0, 4'hF);
    queue_request(CMD_CLEAR, 32'd0, 32'd0, 4'd0);

    // Pause the sender until every directed result is back
    wait_drained();

    // Random episodes of related requests
    sent = 0;
    while (sent < RANDOM_REQUESTS) begin
      kind = $urandom_range(0, 3);
      len = $urandom_range(10, 50);
      step = $urandom_range(1, 1000);
      if ($urandom_range(0, 1) == 1) begin
        queue_request(CMD_CLEAR, $urandom, $urandom, 4'($urandom_range(0, 15)));
        sent++;
      end
      for (int unsigned j = 0; j < len; j++) begin
        pick = $urandom_range(0, 99);
        case (kind)
          0: begin
            // small values so labels collide and dominate often
            cmd = (pick < 60) ? CMD_INSERT : (pick < 75) ? CMD_APPEND :
                  (pick < 96) ? CMD_READ : CMD_CLEAR;
            cost = $urandom_range(0, 15);
            res = $urandom_range(0, 15);
          end
          1: begin
            // staircase front that can fill the store; last one cuts it back
            cmd = (pick < 80) ? CMD_INSERT : CMD_READ;
            cost = j * step + $urandom_range(0, step - 1);
            res = 32'd2_000_000 - j * step;
            if (j == len - 1) begin
              cmd = CMD_INSERT;
              cost = $urandom_range(0, step * 8);
              res = $urandom_range(0, 2_000_000);
            end
          end
          2: begin
            // full-range values on every command
            cmd = cmd_t'($urandom_range(0, 3));
            cost = $urandom;
            res = $urandom;
          end
          default: begin
            // append-heavy so full-store drops and long compactions occur
            cmd = (pick < 50) ? CMD_APPEND : (pick < 75) ? CMD_READ : CMD_INSERT;
            cost = $urandom_range(0, 63);
            res = $urandom_range(0, 63);
          end
        endcase
        queue_request(cmd, cost, res, 4'($urandom_range(0, 15)));
        sent++;
      end
    end

    // Start the long receiver hold-off while the sender keeps going
    while (pending_requests.size() > sent * 2 / 3) @(posedge clk);
    hold_start <= 1'b1;

    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Run drove %0d inserts, %0d appends, %0d clears and %0d reads.",
             cmd_seen[CMD_INSERT], cmd_seen[CMD_APPEND], cmd_seen[CMD_CLEAR],
             cmd_seen[CMD_READ]);
    $display("Checked %0d results: %0d dominated, %0d store full, %0d empty reads.",
             results_checked, status_seen[STAT_DOMINATED], status_seen[STAT_FULL],
             status_seen[STAT_EMPTY]);
    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
`default_nettype wire
